>>> design/atsc_pkg.sv
// ============================================================================
// atsc_pkg: shared types and constants of the terminal sliding attitude block
// Formats, register reset values, step codes, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package atsc_pkg;

  // Data format: signed Q7.16, gains Q4.12
  localparam int DATA_W    = 24;
  localparam int DATA_FRAC = 16;
  localparam int GAIN_FRAC = 12;
  localparam int REG_W     = 48;
  localparam int FIELD_W   = 16;

  // Root unit and divider sizes
  localparam int ROOT_RAD_W = 57;
  localparam int ROOT_W     = 20;
  localparam int DIV_NUM_W  = 34;
  localparam int DIV_DEN_W  = 16;

  // Register reset values
  localparam logic [REG_W-1:0]   RST_XI1     = 48'd8796146697011;
  localparam logic [REG_W-1:0]   RST_XI2     = 48'd21109898479616;
  localparam logic [REG_W-1:0]   RST_K2      = 48'd176174204109;
  localparam logic [REG_W-1:0]   RST_KREG    = 48'd17592454483968;
  localparam logic [REG_W-1:0]   RST_MU      = 48'd3517605085594;
  localparam logic [REG_W-1:0]   RST_KMIN    = 48'd17592991363072;
  localparam logic [REG_W-1:0]   RST_INERTIA = 48'd16862246931078;
  localparam logic [FIELD_W-1:0] RST_DT      = 16'd655;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_XI1, REG_XI2, REG_K2, REG_KREG, REG_MU, REG_KMIN, REG_INERTIA, REG_DT
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_W-1:0]   xi1;
    logic [REG_W-1:0]   xi2;
    logic [REG_W-1:0]   k2;
    logic [REG_W-1:0]   kreg;
    logic [REG_W-1:0]   mu;
    logic [REG_W-1:0]   kmin;
    logic [REG_W-1:0]   inertia;
    logic [FIELD_W-1:0] dt;
  } cfg_t;

  // Datapath step codes
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD,
    OP_ROOT_E_GO, OP_ROOT_E_END, OP_ROOT_V_GO, OP_ROOT_V_END,
    OP_MUL_ME_SE, OP_RND_T1, OP_MUL_XI1, OP_RND_X1,
    OP_MUL_MV_CV, OP_RND_T2, OP_MUL_XI2, OP_RND_X2,
    OP_SURF, OP_MUL_DT, OP_ADAPT, OP_ROOT_S_GO, OP_ROOT_S_END,
    OP_MUL_K, OP_RND_T5, OP_MUL_K2, OP_RND_T6, OP_ASMC,
    OP_MUL_CV2, OP_RND_PV, OP_DIV_GO, OP_DIV_END,
    OP_MUL_XI1_SE, OP_RND_CM, OP_MUL_AC, OP_RND_AB, OP_INNER,
    OP_MUL_JLO, OP_MUL_JHI, OP_TAU, OP_FINISH
  } op_e;

  // Controller states
  typedef enum logic [5:0] {
    S_IDLE,
    S_ROOT_E_GO, S_ROOT_E_END, S_ROOT_V_GO, S_ROOT_V_END,
    S_MUL_ME_SE, S_RND_T1, S_MUL_XI1, S_RND_X1,
    S_MUL_MV_CV, S_RND_T2, S_MUL_XI2, S_RND_X2,
    S_SURF, S_MUL_DT, S_ADAPT, S_ROOT_S_GO, S_ROOT_S_END,
    S_MUL_K, S_RND_T5, S_MUL_K2, S_RND_T6, S_ASMC,
    S_MUL_CV2, S_RND_PV, S_DIV_GO, S_DIV_END,
    S_MUL_XI1_SE, S_RND_CM, S_MUL_AC, S_RND_AB, S_INNER,
    S_MUL_JLO, S_MUL_JHI, S_TAU, S_FINISH
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic axis_ok;
    logic root_done;
    logic div_done;
    logic xi2_zero;
    logic out_free;
  } status_t;

  // Per-axis 16-bit field of a packed 48-bit register
  function automatic logic [FIELD_W-1:0] axis_field(logic [REG_W-1:0] r, logic [1:0] a);
    logic [FIELD_W-1:0] f;
    case (a)
      2'd0:    f = r[15:0];
      2'd1:    f = r[31:16];
      2'd2:    f = r[47:32];
      default: f = '0;
    endcase
    return f;
  endfunction

  // Saturate a wide signed value to the data range
  function automatic logic signed [DATA_W-1:0] sat_data(logic signed [43:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 44'sd8388607)       r = 24'sh7FFFFF;
    else if (x < -44'sd8388608) r = 24'sh800000;
    else                        r = x[DATA_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/atsc_if.sv
// ============================================================================
// atsc_if: channel interfaces
// Input item, result item and configuration write channels, valid/ready.
// ============================================================================
`default_nettype none

interface atsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [23:0] angle_est;
  logic signed [23:0] angle_ref;
  logic signed [23:0] rate_est;
  logic signed [23:0] rate_ref;
  logic signed [23:0] disturbance;
  modport source (output valid, axis, angle_est, angle_ref, rate_est, rate_ref,
                  disturbance, input ready);
  modport sink   (input valid, axis, angle_est, angle_ref, rate_est, rate_ref,
                  disturbance, output ready);
endinterface

interface atsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis_out;
  logic signed [23:0] torque;
  logic signed [23:0] surface;
  logic signed [23:0] angle_error;
  modport source (output valid, axis_out, torque, surface, angle_error, input ready);
  modport sink   (input valid, axis_out, torque, surface, angle_error, output ready);
endinterface

interface atsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/atsc_root.sv
// ============================================================================
// atsc_root: iterative integer square / cube root
// Square root: two radicand bits per cycle. Cube root: three bits per cycle.
// Radicand is left aligned in ROOT_RAD_W bits.
// ============================================================================
`default_nettype none

module atsc_root
  import atsc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  cube_i,
  input  wire logic [ROOT_RAD_W-1:0] rad_i,
  output logic                       done_o,
  output logic [ROOT_W-1:0]          root_o
);

  logic [ROOT_RAD_W-1:0] rad_q, rad_d;
  logic [44:0]           rem_q, rem_d;
  logic [ROOT_W-1:0]     y_q, y_d;
  logic [4:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d, cube_q, cube_d, done_q, done_d;

  logic [44:0]     rem_sq, trial_sq, rem_cb, b_cb;
  logic [ROOT_W-1:0] y2;
  logic [39:0]     yy;

  // One recurrence step for each mode
  always_comb begin
    rem_sq   = {rem_q[42:0], rad_q[ROOT_RAD_W-1 -: 2]};
    trial_sq = {23'd0, y_q, 2'b01};
    rem_cb   = {rem_q[41:0], rad_q[ROOT_RAD_W-1 -: 3]};
    y2       = {y_q[ROOT_W-2:0], 1'b0};
    yy       = y2 * (y2 + 20'd1);
    b_cb     = {4'd0, yy, 1'b0} + {5'd0, yy} + 45'd1;
  end

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    cube_d = cube_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      y_d    = '0;
      cube_d = cube_i;
      cnt_d  = cube_i ? 5'd18 : 5'd19;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cube_q) begin
        rad_d = {rad_q[ROOT_RAD_W-4:0], 3'b000};
        if (rem_cb >= b_cb) begin
          rem_d = rem_cb - b_cb;
          y_d   = y2 + 20'd1;
        end else begin
          rem_d = rem_cb;
          y_d   = y2;
        end
      end else begin
        rad_d = {rad_q[ROOT_RAD_W-3:0], 2'b00};
        if (rem_sq >= trial_sq) begin
          rem_d = rem_sq - trial_sq;
          y_d   = {y_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sq;
          y_d   = {y_q[ROOT_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    y_q    <= y_d;
    cube_q <= cube_d;
  end

  assign done_o = done_q;
  assign root_o = y_q;

endmodule

`default_nettype wire

>>> design/atsc_div.sv
// ============================================================================
// atsc_div: restoring unsigned divider
// One quotient bit per cycle; done pulses after the last.
// ============================================================================
`default_nettype none

module atsc_div
  import atsc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quo_o
);

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] den_q, den_d, rem_q, rem_d;
  logic [5:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_DEN_W:0]   part;
  logic                 ge;

  always_comb begin
    part   = {rem_q, num_q[DIV_NUM_W-1]};
    ge     = part >= {1'b0, den_q};
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'(DIV_NUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits leave
      rem_d = ge ? DIV_DEN_W'(part - {1'b0, den_q}) : part[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

`default_nettype wire

>>> design/atsc_ctrl.sv
// ============================================================================
// atsc_ctrl: step sequencer
// Walks one item through the datapath steps, waiting on the root unit, the
// divider and a free output register.
// ============================================================================
`default_nettype none

module atsc_ctrl
  import atsc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:        if (status_i.in_valid) state_d = S_ROOT_E_GO;
      S_ROOT_E_GO:   state_d = status_i.axis_ok ? S_ROOT_E_END : S_FINISH;
      S_ROOT_E_END:  if (status_i.root_done) state_d = S_ROOT_V_GO;
      S_ROOT_V_GO:   state_d = S_ROOT_V_END;
      S_ROOT_V_END:  if (status_i.root_done) state_d = S_MUL_ME_SE;
      S_MUL_ME_SE:   state_d = S_RND_T1;
      S_RND_T1:      state_d = S_MUL_XI1;
      S_MUL_XI1:     state_d = S_RND_X1;
      S_RND_X1:      state_d = S_MUL_MV_CV;
      S_MUL_MV_CV:   state_d = S_RND_T2;
      S_RND_T2:      state_d = S_MUL_XI2;
      S_MUL_XI2:     state_d = S_RND_X2;
      S_RND_X2:      state_d = S_SURF;
      S_SURF:        state_d = S_MUL_DT;
      S_MUL_DT:      state_d = S_ADAPT;
      S_ADAPT:       state_d = S_ROOT_S_GO;
      S_ROOT_S_GO:   state_d = S_ROOT_S_END;
      S_ROOT_S_END:  if (status_i.root_done) state_d = S_MUL_K;
      S_MUL_K:       state_d = S_RND_T5;
      S_RND_T5:      state_d = S_MUL_K2;
      S_MUL_K2:      state_d = S_RND_T6;
      S_RND_T6:      state_d = S_ASMC;
      S_ASMC:        state_d = S_MUL_CV2;
      S_MUL_CV2:     state_d = S_RND_PV;
      S_RND_PV:      state_d = S_DIV_GO;
      S_DIV_GO:      state_d = status_i.xi2_zero ? S_MUL_XI1_SE : S_DIV_END;
      S_DIV_END:     if (status_i.div_done) state_d = S_MUL_XI1_SE;
      S_MUL_XI1_SE:  state_d = S_RND_CM;
      S_RND_CM:      state_d = S_MUL_AC;
      S_MUL_AC:      state_d = S_RND_AB;
      S_RND_AB:      state_d = S_INNER;
      S_INNER:       state_d = S_MUL_JLO;
      S_MUL_JLO:     state_d = S_MUL_JHI;
      S_MUL_JHI:     state_d = S_TAU;
      S_TAU:         state_d = S_FINISH;
      S_FINISH:      if (status_i.out_free) state_d = S_IDLE;
      default:       state_d = S_IDLE;
    endcase
  end

  // Step command
  always_comb begin
    unique case (state_q)
      S_IDLE:        cmd_o.op = OP_LOAD;
      S_ROOT_E_GO:   cmd_o.op = OP_ROOT_E_GO;
      S_ROOT_E_END:  cmd_o.op = OP_ROOT_E_END;
      S_ROOT_V_GO:   cmd_o.op = OP_ROOT_V_GO;
      S_ROOT_V_END:  cmd_o.op = OP_ROOT_V_END;
      S_MUL_ME_SE:   cmd_o.op = OP_MUL_ME_SE;
      S_RND_T1:      cmd_o.op = OP_RND_T1;
      S_MUL_XI1:     cmd_o.op = OP_MUL_XI1;
      S_RND_X1:      cmd_o.op = OP_RND_X1;
      S_MUL_MV_CV:   cmd_o.op = OP_MUL_MV_CV;
      S_RND_T2:      cmd_o.op = OP_RND_T2;
      S_MUL_XI2:     cmd_o.op = OP_MUL_XI2;
      S_RND_X2:      cmd_o.op = OP_RND_X2;
      S_SURF:        cmd_o.op = OP_SURF;
      S_MUL_DT:      cmd_o.op = OP_MUL_DT;
      S_ADAPT:       cmd_o.op = OP_ADAPT;
      S_ROOT_S_GO:   cmd_o.op = OP_ROOT_S_GO;
      S_ROOT_S_END:  cmd_o.op = OP_ROOT_S_END;
      S_MUL_K:       cmd_o.op = OP_MUL_K;
      S_RND_T5:      cmd_o.op = OP_RND_T5;
      S_MUL_K2:      cmd_o.op = OP_MUL_K2;
      S_RND_T6:      cmd_o.op = OP_RND_T6;
      S_ASMC:        cmd_o.op = OP_ASMC;
      S_MUL_CV2:     cmd_o.op = OP_MUL_CV2;
      S_RND_PV:      cmd_o.op = OP_RND_PV;
      S_DIV_GO:      cmd_o.op = OP_DIV_GO;
      S_DIV_END:     cmd_o.op = OP_DIV_END;
      S_MUL_XI1_SE:  cmd_o.op = OP_MUL_XI1_SE;
      S_RND_CM:      cmd_o.op = OP_RND_CM;
      S_MUL_AC:      cmd_o.op = OP_MUL_AC;
      S_RND_AB:      cmd_o.op = OP_RND_AB;
      S_INNER:       cmd_o.op = OP_INNER;
      S_MUL_JLO:     cmd_o.op = OP_MUL_JLO;
      S_MUL_JHI:     cmd_o.op = OP_MUL_JHI;
      S_TAU:         cmd_o.op = OP_TAU;
      S_FINISH:      cmd_o.op = OP_FINISH;
      default:       cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An item with a bad axis skips straight to the result
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT_E_GO && !status_i.axis_ok) |=> state_q == S_FINISH)
    else $error("bad axis did not bypass");

  // A written result returns the sequencer to idle
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && status_i.out_free) |=> state_q == S_IDLE)
    else $error("finish did not return to idle");

  // Idle holds with no item offered
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !status_i.in_valid) |=> state_q == S_IDLE)
    else $error("left idle without an item");

endmodule

`default_nettype wire

>>> design/atsc_dp.sv
// ============================================================================
// atsc_dp: datapath
// Operand registers, one shared registered multiplier, the root unit, the
// divider, per-axis switching gains and the result register.
// ============================================================================
`default_nettype none

module atsc_dp
  import atsc_pkg::*;
#(
  parameter int AXIS_COUNT = 3
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire cmd_t    cmd_i,
  output status_t      status_o,
  atsc_in_if.sink      in_i,
  atsc_out_if.source   out_o
);

  localparam int GW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  op_e op;
  assign op = cmd_i.op;

  // Item registers
  logic [1:0]               axis_q;
  logic signed [DATA_W-1:0] e_q, v_q, d_q, s_q, k_q, tau_q;
  logic [DATA_W-1:0]        me_q, mv_q, ms_q;
  logic [ROOT_W-1:0]        se_q, cv_q, sms_q;
  logic [63:0]              prod_q;
  logic [27:0]              ta_q, tb_q;
  logic [31:0]              x1_q, x2_q;
  logic                     above_q, ineg_q;
  logic signed [31:0]       asmc_q;
  logic [21:0]              pv_q;
  logic [30:0]              am_q;
  logic [24:0]              cm_q;
  logic [40:0]              ab_q;
  logic [41:0]              mi_q;
  logic [36:0]              lo_q;
  logic signed [DATA_W-1:0] gain_q [AXIS_COUNT];

  logic                     out_valid_q;
  logic [1:0]               out_axis_q;
  logic signed [DATA_W-1:0] out_tau_q, out_s_q, out_e_q;

  // Per-axis fields
  logic [FIELD_W-1:0] xi1, xi2, k2, kreg, mu, kmin, jn;
  assign xi1  = axis_field(cfg_i.xi1, axis_q);
  assign xi2  = axis_field(cfg_i.xi2, axis_q);
  assign k2   = axis_field(cfg_i.k2, axis_q);
  assign kreg = axis_field(cfg_i.kreg, axis_q);
  assign mu   = axis_field(cfg_i.mu, axis_q);
  assign kmin = axis_field(cfg_i.kmin, axis_q);
  assign jn   = axis_field(cfg_i.inertia, axis_q);

  logic axis_ok, in_fire, out_free;
  assign axis_ok  = 32'(axis_q) < AXIS_COUNT;
  assign in_i.ready = (op == OP_LOAD);
  assign in_fire  = in_i.valid && (op == OP_LOAD);
  assign out_free = !out_valid_q || out_o.ready;

  // Root unit and divider
  logic                  root_start, root_cube, root_done;
  logic [ROOT_RAD_W-1:0] root_rad;
  logic [ROOT_W-1:0]     root_val;
  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;

  assign root_start = (op == OP_ROOT_E_GO && axis_ok) || op == OP_ROOT_V_GO ||
                      op == OP_ROOT_S_GO;
  assign root_cube  = (op == OP_ROOT_V_GO);
  always_comb begin
    case (op)
      OP_ROOT_V_GO: root_rad = {1'b0, mv_q, 32'd0};
      OP_ROOT_S_GO: root_rad = {ms_q, 33'd0};
      default:      root_rad = {me_q, 33'd0};
    endcase
  end

  atsc_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .cube_i  (root_cube),
    .rad_i   (root_rad),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // pv * 3072 + xi2 / 2
  assign div_num   = {1'b0, pv_q, 11'd0} + {2'b0, pv_q, 10'd0} + {19'd0, xi2[15:1]};
  assign div_start = (op == OP_DIV_GO) && (xi2 != '0);

  atsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (xi2),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [DATA_W-1:0] k_mag;
  assign k_mag = k_q[DATA_W-1] ? DATA_W'(-k_q) : DATA_W'(k_q);

  always_comb begin
    mul_en = 1'b1;
    case (op)
      OP_MUL_ME_SE:  begin mul_a = 32'(me_q);  mul_b = 32'(se_q);  end
      OP_MUL_XI1:    begin mul_a = 32'(xi1);   mul_b = 32'(ta_q);  end
      OP_MUL_MV_CV:  begin mul_a = 32'(mv_q);  mul_b = 32'(cv_q);  end
      OP_MUL_XI2:    begin mul_a = 32'(xi2);   mul_b = 32'(ta_q);  end
      OP_MUL_DT:     begin mul_a = 32'(cfg_i.dt); mul_b = 32'(above_q ? kreg : kmin); end
      OP_MUL_K:      begin mul_a = 32'(k_mag); mul_b = 32'(sms_q); end
      OP_MUL_K2:     begin mul_a = 32'(k2);    mul_b = 32'(ms_q);  end
      OP_MUL_CV2:    begin mul_a = 32'(cv_q);  mul_b = 32'(cv_q);  end
      OP_MUL_XI1_SE: begin mul_a = 32'(xi1);   mul_b = 32'(se_q);  end
      OP_MUL_AC:     begin mul_a = 32'(am_q);  mul_b = 32'(cm_q);  end
      OP_MUL_JLO:    begin mul_a = 32'(jn);    mul_b = 32'(mi_q[20:0]); end
      OP_MUL_JHI:    begin mul_a = 32'(jn);    mul_b = 32'(mi_q[41:21]); end
      default:       begin mul_a = '0; mul_b = '0; mul_en = 1'b0; end
    endcase
  end

  // Step arithmetic
  logic signed [24:0] e_diff, v_diff;
  logic signed [DATA_W-1:0] e_new, v_new, k_cur, k_new, s_new;
  logic signed [35:0] s_sum;
  logic [20:0]        inc;
  logic signed [25:0] delta;
  logic [35:0]        lhs, rhs;
  logic signed [31:0] p5, p6, asmc_new;
  logic [39:0]        prod3;
  logic signed [42:0] inner;
  logic [58:0]        total;
  logic [42:0]        tau_mag;
  logic signed [DATA_W-1:0] tau_new;

  always_comb begin
    e_diff = {in_i.angle_est[23], in_i.angle_est} - {in_i.angle_ref[23], in_i.angle_ref};
    v_diff = {in_i.rate_est[23], in_i.rate_est} - {in_i.rate_ref[23], in_i.rate_ref};
    e_new  = sat_data({{19{e_diff[24]}}, e_diff});
    v_new  = sat_data({{19{v_diff[24]}}, v_diff});

    // surface: e plus the two signed power terms
    s_sum = {{12{e_q[23]}}, e_q}
          + (e_q[23] ? -$signed({4'd0, x1_q}) : $signed({4'd0, x1_q}))
          + (v_q[23] ? -$signed({4'd0, x2_q}) : $signed({4'd0, x2_q}));
    s_new = sat_data({{8{s_sum[35]}}, s_sum});
    k_cur = gain_q[axis_q[GW-1:0]];

    // gain step
    inc   = 21'((prod_q + 64'd2048) >> GAIN_FRAC);
    lhs   = {ms_q, 12'd0};
    rhs   = {4'd0, mu, 16'd0};
    if (!above_q || lhs > rhs) delta = $signed({5'd0, inc});
    else if (lhs < rhs)        delta = -$signed({5'd0, inc});
    else                       delta = '0;
    k_new = sat_data({{20{k_q[23]}}, k_q} + {{18{delta[25]}}, delta});

    // reaching terms
    p5 = (k_q[23] ^ s_q[23]) ? -$signed({4'd0, ta_q}) : $signed({4'd0, ta_q});
    p6 = s_q[23] ? -$signed({4'd0, tb_q}) : $signed({4'd0, tb_q});
    asmc_new = -p5 - p6 - {{8{d_q[23]}}, d_q};

    prod3 = {prod_q[38:0], 1'b0} + {1'b0, prod_q[38:0]};
    inner = {{11{asmc_q[31]}}, asmc_q}
          - (v_q[23] ? -$signed({2'd0, ab_q}) : $signed({2'd0, ab_q}));

    // torque from the two partial products
    total   = {1'b0, prod_q[36:0], 21'd0} + {22'd0, lo_q};
    tau_mag = 43'((total + 59'd32768) >> DATA_FRAC);
    if (ineg_q) tau_new = (tau_mag > 43'd8388608) ? 24'sh800000 : -$signed(tau_mag[23:0]);
    else        tau_new = (tau_mag > 43'd8388607) ? 24'sh7FFFFF : $signed(tau_mag[23:0]);
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    case (op)
      OP_LOAD: if (in_fire) begin
        axis_q <= in_i.axis;
        e_q    <= e_new;
        v_q    <= v_new;
        d_q    <= in_i.disturbance;
        me_q   <= e_new[23] ? DATA_W'(-e_new) : DATA_W'(e_new);
        mv_q   <= v_new[23] ? DATA_W'(-v_new) : DATA_W'(v_new);
      end
      OP_ROOT_E_END: if (root_done) se_q <= root_val;
      OP_ROOT_V_END: if (root_done) cv_q <= root_val;
      OP_ROOT_S_END: if (root_done) sms_q <= root_val;
      OP_RND_T1, OP_RND_T2, OP_RND_T5: ta_q <= 28'((prod_q + 64'd32768) >> DATA_FRAC);
      OP_RND_T6: tb_q <= 28'((prod_q + 64'd2048) >> GAIN_FRAC);
      OP_RND_X1: x1_q <= 32'((prod_q + 64'd2048) >> GAIN_FRAC);
      OP_RND_X2: x2_q <= 32'((prod_q + 64'd2048) >> GAIN_FRAC);
      OP_SURF: begin
        s_q     <= s_new;
        ms_q    <= s_new[23] ? DATA_W'(-s_new) : DATA_W'(s_new);
        k_q     <= k_cur;
        above_q <= $signed({k_cur, 12'd0}) > $signed({5'd0, kmin, 16'd0});
      end
      OP_ADAPT:  k_q    <= k_new;
      OP_ASMC:   asmc_q <= asmc_new;
      OP_RND_PV: pv_q   <= 22'((prod_q + 64'd32768) >> DATA_FRAC);
      OP_DIV_GO: if (xi2 == '0) am_q <= '0;
      OP_DIV_END: if (div_done) begin
        am_q <= (div_quo > 34'h7FFFFFFF) ? 31'h7FFFFFFF : div_quo[30:0];
      end
      OP_RND_CM: cm_q <= 25'((prod3 + 40'd4096) >> (GAIN_FRAC + 1));
      OP_RND_AB: ab_q <= {10'd0, am_q} + 41'((prod_q + 64'd32768) >> DATA_FRAC);
      OP_INNER: begin
        ineg_q <= inner[42];
        mi_q   <= inner[42] ? 42'(-inner) : 42'(inner);
      end
      OP_MUL_JHI: lo_q  <= prod_q[36:0];
      OP_TAU:     tau_q <= tau_new;
      default: ;
    endcase
  end

  // Switching gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXIS_COUNT; i++) gain_q[i] <= '0;
    end else if (op == OP_ADAPT) begin
      gain_q[axis_q[GW-1:0]] <= k_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_FINISH && out_free) begin
      out_axis_q <= axis_q;
      out_tau_q  <= axis_ok ? tau_q : '0;
      out_s_q    <= axis_ok ? s_q : '0;
      out_e_q    <= e_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.axis_out    = out_axis_q;
  assign out_o.torque      = out_tau_q;
  assign out_o.surface     = out_s_q;
  assign out_o.angle_error = out_e_q;

  always_comb begin
    status_o.in_valid  = in_i.valid;
    status_o.axis_ok   = axis_ok;
    status_o.root_done = root_done;
    status_o.div_done  = div_done;
    status_o.xi2_zero  = (xi2 == '0);
    status_o.out_free  = out_free;
  end

endmodule

`default_nettype wire

>>> design/adaptive_terminal_sliding_attitude_ctrl_top.sv
// ============================================================================
// adaptive_terminal_sliding_attitude_ctrl_top: one-axis sliding attitude step
// Per item: angle/rate errors, terminal sliding surface, switching gain
// adaptation and torque for the named axis.
//
// Usage:
//  - in_i carries one axis item (valid/ready); out_o returns one result per
//    item (axis, torque, surface, angle error); cfg_i writes the eight
//    configuration registers by index and is always ready. Write configuration while idle.
//  - One item is worked at a time. Its time from acceptance to result is set
//    by the three passes of the bit-serial root unit, the divider (skipped
//    when the axis rate gain is zero) and the shared multiplier steps; an
//    item whose axis index is out of range skips straight to the result.
//  - The result sits in an output register; the next item is accepted while
//    it waits. If the receiver stalls, the following item finishes and then
//    holds until the register frees.
//  - Reset loads the register defaults and clears all switching gains.
// ============================================================================
`default_nettype none

module adaptive_terminal_sliding_attitude_ctrl_top
  import atsc_pkg::*;
#(
  parameter int AXIS_COUNT = 3
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  atsc_in_if.sink    in_i,
  atsc_out_if.source out_o,
  atsc_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // Configuration register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xi1     <= RST_XI1;
      cfg_q.xi2     <= RST_XI2;
      cfg_q.k2      <= RST_K2;
      cfg_q.kreg    <= RST_KREG;
      cfg_q.mu      <= RST_MU;
      cfg_q.kmin    <= RST_KMIN;
      cfg_q.inertia <= RST_INERTIA;
      cfg_q.dt      <= RST_DT;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_XI1:     cfg_q.xi1     <= cfg_i.data;
        REG_XI2:     cfg_q.xi2     <= cfg_i.data;
        REG_K2:      cfg_q.k2      <= cfg_i.data;
        REG_KREG:    cfg_q.kreg    <= cfg_i.data;
        REG_MU:      cfg_q.mu      <= cfg_i.data;
        REG_KMIN:    cfg_q.kmin    <= cfg_i.data;
        REG_INERTIA: cfg_q.inertia <= cfg_i.data;
        REG_DT:      cfg_q.dt      <= cfg_i.data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  atsc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  atsc_dp #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
